FILE: rtl/fq_pkg.sv
// Package for the first-in first-out queue with search.
// Holds the sizes, operation and status codes, the cell control struct and
// the word conversion functions. Depends on nothing.
package fq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] REMOVED_NONE = -32'sd1;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic held;
  } fq_cell_ctrl_t;

  function automatic word_t to_word(input logic signed [31:0] raw);
    logic signed [63:0] ext;
    ext = 64'(raw);
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] to_field(input word_t w);
    logic signed [DATA_WIDTH-1:0] sw;
    logic signed [63:0] ext;
    sw = w;
    ext = 64'(sw);
    return ext[31:0];
  endfunction

endpackage

FILE: rtl/fq_if.sv
// Handshake interfaces for the queue's operation and result channels.
// Depends on fq_pkg.
interface fq_item_if
  import fq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface fq_result_if
  import fq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic               found;
  logic [4:0]         entry_count;
  logic signed [31:0] front_value;
  logic signed [31:0] tail_value;

  modport source (output valid, output status, output removed_value, output found,
                  output entry_count, output front_value, output tail_value,
                  input ready);
  modport sink (input valid, input status, input removed_value, input found,
                input entry_count, input front_value, input tail_value,
                output ready);
endinterface

FILE: rtl/fq_cell.sv
// One storage cell of the queue chain: holds a word, loads a new word or
// takes its neighbour's word on a dequeue, and compares against the key.
// Depends on fq_pkg.
module fq_cell
  import fq_pkg::*;
(
  input  logic          clk,
  input  fq_cell_ctrl_t ctrl,
  input  word_t         load_word,
  input  word_t         shift_word,
  input  word_t         key,
  output word_t         data,
  output logic          match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_word;
    end else if (ctrl.shift) begin
      data <= shift_word;
    end
  end

  assign match = ctrl.held && (data == key);

endmodule

FILE: rtl/fifo_queue_with_search.sv
// Top level of the first-in first-out queue with search.
// Depends on fq_pkg, fq_if and fq_cell.
//
// The queue is a row of cells with the oldest word in cell 0; a dequeue moves
// every word one cell forward and an enqueue loads the cell just past the
// newest word. Each operation gives one result in the cycle after its
// transfer, held in an output register; a new operation is taken when no
// result is held or as the held one is taken, so one operation a cycle is
// kept up while results are taken. A search compares all held cells at once.
module fifo_queue_with_search
  import fq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fq_item_if.sink     item,
  fq_result_if.source result
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  word_t              tail;
  word_t              data [DEPTH];
  logic [DEPTH-1:0]   match;
  fq_cell_ctrl_t      ctrl [DEPTH];
  word_t              key;
  logic               accept;
  logic               empty;
  logic               full;
  logic               enq_ok;
  logic               deq_ok;
  logic [1:0]         status_next;
  logic signed [31:0] removed_next;
  logic               found_next;
  logic signed [31:0] front_next;
  logic signed [31:0] tail_next;

  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign key        = to_word(item.value);
  assign empty      = (count == '0);
  assign full       = (count == COUNT_W'(DEPTH));
  assign enq_ok     = (item.opcode == OP_ENQ) && !full;
  assign deq_ok     = (item.opcode == OP_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t shift_word;

    if (i == DEPTH - 1) begin : g_last
      assign shift_word = '0;
    end else begin : g_mid
      assign shift_word = data[i+1];
    end

    assign ctrl[i].shift = accept && deq_ok;
    assign ctrl[i].load  = accept && enq_ok && (count == COUNT_W'(i));
    assign ctrl[i].held  = (COUNT_W'(i) < count);

    fq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .load_word  (key),
      .shift_word (shift_word),
      .key        (key),
      .data       (data[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    status_next  = ST_OK;
    removed_next = REMOVED_NONE;
    found_next   = 1'b0;
    count_next   = count;
    unique case (item.opcode)
      OP_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          removed_next = to_field(data[0]);
          count_next   = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        found_next = |match;
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase

    if (count_next == '0) begin
      front_next = '0;
      tail_next  = '0;
    end else begin
      if (deq_ok) begin
        front_next = to_field(data[1]);
      end else if (enq_ok && empty) begin
        front_next = to_field(key);
      end else begin
        front_next = to_field(data[0]);
      end
      if (enq_ok) begin
        tail_next = to_field(key);
      end else begin
        tail_next = to_field(tail);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      result.valid <= accept || (result.valid && !result.ready);
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (enq_ok) begin
        tail <= key;
      end
      result.status        <= status_next;
      result.removed_value <= removed_next;
      result.found         <= found_next;
      result.entry_count   <= 5'(count_next);
      result.front_value   <= front_next;
      result.tail_value    <= tail_next;
    end
  end

endmodule
